// ----- hdl/ntc_pkg.sv -----
package ntc_pkg;

  // averaging window: 2**AVG_LOG2 samples
  localparam int AVG_LOG2  = 10;
  localparam int SAMPLE_W  = 10;
  localparam int SUM_W     = SAMPLE_W + AVG_LOG2;
  localparam int COUNT_W   = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
  localparam int TEMP_W    = 12;
  localparam int OFFSET_W  = 9;
  localparam int LIMIT_W   = 10;

  // linear segment tables
  localparam int SEG_COUNT = 10;
  localparam int SLOPE_W   = 12;
  localparam int ICPT_W    = 22;
  localparam int PROD_W    = SAMPLE_W + SLOPE_W;
  localparam int DIFF_W    = 24;
  localparam int FRAC_W    = 10;
  localparam int QUOT_W    = DIFF_W - FRAC_W;

  localparam logic [SAMPLE_W-1:0] SEG_FLOOR [SEG_COUNT] = '{
    10'd967, 10'd928, 10'd867, 10'd784, 10'd681,
    10'd568, 10'd456, 10'd355, 10'd270, 10'd203
  };
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_COUNT] = '{
    12'd4064, 12'd2503, 12'd1672, 12'd1227, 12'd998,
    12'd905,  12'd912,  12'd1010, 12'd1205, 12'd1521
  };
  localparam logic [ICPT_W-1:0] SEG_ICPT [SEG_COUNT] = '{
    22'd3634688, 22'd2121523, 22'd1350451, 22'd963461, 22'd783544,
    22'd719657,  22'd723139,  22'd767048,  22'd835963, 22'd920842
  };

  // register indexes on the config port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_LIMIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 10'd203;
  localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RST  = 10'd994;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_SHORT = 2'd1,
    FAULT_OPEN  = 2'd2
  } fault_t;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] temp_offset;
    logic [LIMIT_W-1:0]         short_limit;
    logic [LIMIT_W-1:0]         open_limit;
  } cfg_t;

endpackage

// ----- hdl/ntc_averaging_temperature_converter_top.sv -----
// Channel   Dir  Fields (lsb first)                       Beat when
// s_axis    in   tdata: sample[9:0], zero pad to 16       s_tvalid & s_tready
// m_axis    out  tdata: temperature[11:0] signed, pad     m_tvalid & m_tready
//                tuser: fault[1:0] (0 none/1 short/2 open)
// cfg       in   cfg_index: register, cfg_data: value     cfg_valid & cfg_ready
//
// Throughput: one sample beat per clock unless stalled. Every 1024th sample yields
// one result beat, through the average register, then segment lookup, 10x12
// multiply, subtract, shift and offset add into the result register.
// Reset (rst, sync, high): sum/count cleared, stored temperature 0, offset 0,
// short limit 203, open limit 994.
// Stalls: the average register and result register each hold one beat; input
// stalls only when both are full and m_tready is low.
// Config writes are always taken (cfg_ready tied high); write only when idle.
module ntc_averaging_temperature_converter_top (
  input  logic                             clk,
  input  logic                             rst,
  // sample stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // [9:0] sample
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [11:0] temperature
  output logic [1:0]                       m_tuser,   // [1:0] fault
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ntc_pkg::LIMIT_W-1:0]      cfg_data
);

  ntc_pkg::cfg_t                     cfg;
  logic                              avg_valid;
  logic                              avg_ready;
  logic [ntc_pkg::SAMPLE_W-1:0]      avg;
  logic signed [ntc_pkg::TEMP_W-1:0] temperature;
  ntc_pkg::fault_t                   fault;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_offset <= '0;
      cfg.short_limit <= ntc_pkg::SHORT_LIMIT_RST;
      cfg.open_limit  <= ntc_pkg::OPEN_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntc_pkg::CFG_TEMP_OFFSET: cfg.temp_offset <= cfg_data[ntc_pkg::OFFSET_W-1:0];
        ntc_pkg::CFG_SHORT_LIMIT: cfg.short_limit <= cfg_data;
        ntc_pkg::CFG_OPEN_LIMIT:  cfg.open_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  ntc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[ntc_pkg::SAMPLE_W-1:0]),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg       (avg)
  );

  ntc_conv u_conv (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .avg_valid        (avg_valid),
    .avg_ready        (avg_ready),
    .avg              (avg),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .last_temperature (temperature),
    .fault            (fault)
  );

  assign m_tdata = {{(16 - ntc_pkg::TEMP_W){1'b0}}, temperature};
  assign m_tuser = fault;

endmodule

// ----- hdl/ntc_accum.sv -----
module ntc_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ntc_pkg::SAMPLE_W-1:0]  sample,
  output logic                          avg_valid,
  input  logic                          avg_ready,
  output logic [ntc_pkg::SAMPLE_W-1:0]  avg
);

  logic [ntc_pkg::SUM_W-1:0]   sample_sum;
  logic [ntc_pkg::COUNT_W-1:0] sample_count;
  logic [ntc_pkg::SUM_W-1:0]   sum_next;
  logic                        accept;
  logic                        last_beat;

  assign in_ready  = !avg_valid || avg_ready;
  assign accept    = in_valid && in_ready;
  assign sum_next  = sample_sum + ntc_pkg::SUM_W'(sample);
  assign last_beat = (ntc_pkg::AVG_LOG2 == 0) || (sample_count == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      avg_valid    <= 1'b0;
    end else begin
      if (avg_valid && avg_ready) begin
        avg_valid <= 1'b0;
      end
      if (accept) begin
        if (last_beat) begin
          sample_sum   <= '0;
          sample_count <= '0;
          avg_valid    <= 1'b1;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_beat) begin
      avg <= sum_next[ntc_pkg::SUM_W-1:ntc_pkg::AVG_LOG2];
    end
  end

  // empty window holds an empty sum
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (sample_count == '0) |-> (sample_sum == '0))
    else $error("sum not cleared with count");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last_beat) |=> (avg_valid && sample_count == '0))
    else $error("window end did not post an average");

  a_no_avg_midwindow: assert property (@(posedge clk) disable iff (rst)
    (accept && !last_beat && !avg_valid) |=> !avg_valid)
    else $error("average posted mid-window");

endmodule

// ----- hdl/ntc_conv.sv -----
module ntc_conv (
  input  logic                              clk,
  input  logic                              rst,
  input  ntc_pkg::cfg_t                     cfg,
  input  logic                              avg_valid,
  output logic                              avg_ready,
  input  logic [ntc_pkg::SAMPLE_W-1:0]      avg,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0] last_temperature,
  output ntc_pkg::fault_t                   fault
);

  logic [ntc_pkg::SLOPE_W-1:0]       slope;
  logic [ntc_pkg::ICPT_W-1:0]        icpt;
  logic [ntc_pkg::PROD_W-1:0]        prod;
  logic signed [ntc_pkg::DIFF_W-1:0] diff;
  logic signed [ntc_pkg::QUOT_W-1:0] quot;
  logic signed [ntc_pkg::QUOT_W-1:0] temp_full;
  ntc_pkg::fault_t                   fault_next;
  logic                              load;

  // first segment whose floor lies below the average; top segment otherwise
  always_comb begin
    slope = ntc_pkg::SEG_SLOPE[ntc_pkg::SEG_COUNT-1];
    icpt  = ntc_pkg::SEG_ICPT[ntc_pkg::SEG_COUNT-1];
    for (int i = ntc_pkg::SEG_COUNT - 1; i >= 0; i--) begin
      if (avg > ntc_pkg::SEG_FLOOR[i]) begin
        slope = ntc_pkg::SEG_SLOPE[i];
        icpt  = ntc_pkg::SEG_ICPT[i];
      end
    end
  end

  assign prod = ntc_pkg::PROD_W'(avg) * ntc_pkg::PROD_W'(slope);
  assign diff = $signed({{(ntc_pkg::DIFF_W-ntc_pkg::ICPT_W){1'b0}}, icpt})
              - $signed({{(ntc_pkg::DIFF_W-ntc_pkg::PROD_W){1'b0}}, prod});
  // arithmetic shift is floor division by 1024
  assign quot = ntc_pkg::QUOT_W'(diff >>> ntc_pkg::FRAC_W);
  assign temp_full = quot + ntc_pkg::QUOT_W'(cfg.temp_offset);

  always_comb begin
    if (avg <= cfg.short_limit) begin
      fault_next = ntc_pkg::FAULT_SHORT;
    end else if (avg >= cfg.open_limit) begin
      fault_next = ntc_pkg::FAULT_OPEN;
    end else begin
      fault_next = ntc_pkg::FAULT_NONE;
    end
  end

  assign avg_ready = !out_valid || out_ready;
  assign load      = avg_valid && avg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      last_temperature <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (fault_next == ntc_pkg::FAULT_NONE) begin
          last_temperature <= temp_full[ntc_pkg::TEMP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fault <= fault_next;
    end
  end

  a_fault_keeps_temp: assert property (@(posedge clk) disable iff (rst)
    (load && fault_next != ntc_pkg::FAULT_NONE) |=> $stable(last_temperature))
    else $error("faulted average changed stored temperature");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fault == ntc_pkg::FAULT_NONE || fault == ntc_pkg::FAULT_SHORT
                   || fault == ntc_pkg::FAULT_OPEN))
    else $error("bad fault code on output");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(avg_valid))
    else $error("result without an average");

endmodule
